// ===== rtl/assert_macros.svh =====
// Shared assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Check that cond never holds outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/yrc_pkg.sv =====
package yrc_pkg;

  typedef enum logic [2:0] {
    FMT_YUY2   = 3'd0,
    FMT_UYVY   = 3'd1,
    FMT_PLANAR = 3'd2,
    FMT_RGB565 = 3'd3,
    FMT_BGRX32 = 3'd4,
    FMT_BGR24  = 3'd5
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_YCC    = 2'd1,
    KIND_DIRECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  // Accumulator width: the blue sum reaches about 137k, so 19 bits plus margin.
  localparam int SumW = 20;

  localparam logic signed [SumW-1:0] CoefY   = SumW'(298);
  localparam logic signed [SumW-1:0] CoefRe  = SumW'(409);
  localparam logic signed [SumW-1:0] CoefGd  = SumW'(100);
  localparam logic signed [SumW-1:0] CoefGe  = SumW'(208);
  localparam logic signed [SumW-1:0] CoefBd  = SumW'(516);
  localparam logic signed [SumW-1:0] RoundC  = SumW'(128);
  localparam logic signed [8:0]      LumaOff = 9'sd16;
  localparam logic signed [8:0]      ChrOff  = 9'sd128;

  // Floor shift by 8 and saturate to 0..255.
  function automatic logic [7:0] clamp_px(input logic signed [SumW-1:0] acc);
    logic [7:0] res;
    if (acc[SumW-1]) begin
      res = 8'd0;
    end else if (|acc[SumW-2:16]) begin
      res = 8'hFF;
    end else begin
      res = acc[15:8];
    end
    return res;
  endfunction

endpackage

// ===== rtl/yrc_lane.sv =====
module yrc_lane (
  input  logic            clk,
  input  logic [7:0]      y,
  input  logic [7:0]      cb,
  input  logic [7:0]      cr,
  output yrc_pkg::rgb_t   pix
);

  localparam int W = yrc_pkg::SumW;

  logic signed [8:0]   c, d, e;
  logic signed [W-1:0] cw, dw, ew;
  logic signed [W-1:0] p_y, p_re, p_gd, p_ge, p_bd;

  assign c  = $signed({1'b0, y})  - yrc_pkg::LumaOff;
  assign d  = $signed({1'b0, cb}) - yrc_pkg::ChrOff;
  assign e  = $signed({1'b0, cr}) - yrc_pkg::ChrOff;
  assign cw = W'(c);
  assign dw = W'(d);
  assign ew = W'(e);

  // Products, then sums with clamp.
  always_ff @(posedge clk) begin
    p_y  <= cw * yrc_pkg::CoefY;
    p_re <= ew * yrc_pkg::CoefRe;
    p_gd <= dw * yrc_pkg::CoefGd;
    p_ge <= ew * yrc_pkg::CoefGe;
    p_bd <= dw * yrc_pkg::CoefBd;
    pix.r <= yrc_pkg::clamp_px(p_y + p_re + yrc_pkg::RoundC);
    pix.g <= yrc_pkg::clamp_px(p_y - p_gd - p_ge + yrc_pkg::RoundC);
    pix.b <= yrc_pkg::clamp_px(p_y + p_bd + yrc_pkg::RoundC);
  end

endmodule

// ===== rtl/yrc_merge.sv =====
`include "assert_macros.svh"

module yrc_merge (
  input  logic           clk,
  input  logic           rst,
  input  yrc_pkg::ctl_t  ctl,
  input  yrc_pkg::rgb_t  pix0,
  input  yrc_pkg::rgb_t  pix1,
  input  yrc_pkg::rgb_t  direct,
  output logic           strobe,
  output logic           last,
  output yrc_pkg::rgb_t  pix_out
);

  logic          pend;
  yrc_pkg::rgb_t pend_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      pend   <= 1'b0;
      if (pend) begin
        // second pixel of a luma pair
        strobe  <= 1'b1;
        last    <= 1'b1;
        pix_out <= pend_pix;
      end else if (ctl.valid) begin
        case (ctl.kind)
          yrc_pkg::KIND_YCC: begin
            strobe   <= 1'b1;
            last     <= 1'b0;
            pix_out  <= pix0;
            pend     <= 1'b1;
            pend_pix <= pix1;
          end
          yrc_pkg::KIND_DIRECT: begin
            strobe  <= 1'b1;
            last    <= 1'b1;
            pix_out <= direct;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_CLK(a_pair_follows, clk, rst, strobe && !last |=> strobe && last,
              "first pixel of a pair not followed by the second")
  `ASSERT_NEVER(a_no_collide, clk, rst, pend && ctl.valid,
                "new word reached the merge stage while a pixel was pending")

endmodule

// ===== rtl/yuv_rgb_pixel_format_converter.sv =====
// The first pixel of a taken word reaches the output ports through the decode register,
// lane product register, lane sum/clamp register and output register.
// Throughput: one word per cycle for one-pixel formats; the output port sends one
// pixel per cycle, so a two-pixel word raises busy for one cycle.
// The receiver cannot stall. Synchronous reset clears the format to YUY2 and
// drops all words in flight.
`include "assert_macros.svh"

module yuv_rgb_pixel_format_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        format_we,
  input  logic [2:0]  format_data,
  input  logic        start,
  input  logic [31:0] pixel_word,
  output logic        busy,
  output logic        strobe,
  output logic [7:0]  blue,
  output logic [7:0]  green,
  output logic [7:0]  red,
  output logic        last
);

  logic [2:0]     pixel_format;
  logic           accept;
  logic [7:0]     b0, b1, b2, b3;
  logic [7:0]     in_y0, in_y1, in_cb, in_cr;
  yrc_pkg::kind_t in_kind;
  yrc_pkg::rgb_t  in_direct;

  yrc_pkg::ctl_t  ctl_a, ctl_b, ctl_c;
  logic [7:0]     y0_a, y1_a, cb_a, cr_a;
  yrc_pkg::rgb_t  direct_a, direct_b, direct_c;
  yrc_pkg::rgb_t  pix0, pix1, pix_out;

  assign accept = start && !busy;
  assign b0 = pixel_word[7:0];
  assign b1 = pixel_word[15:8];
  assign b2 = pixel_word[23:16];
  assign b3 = pixel_word[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= yrc_pkg::FMT_YUY2;
    end else if (format_we) begin
      pixel_format <= format_data;
    end
  end

  always_comb begin
    in_kind   = yrc_pkg::KIND_NONE;
    in_y0     = b0;
    in_y1     = b2;
    in_cb     = b1;
    in_cr     = b3;
    in_direct = '{b: b0, g: b1, r: b2};
    unique case (yrc_pkg::fmt_t'(pixel_format))
      yrc_pkg::FMT_YUY2: begin
        in_kind = yrc_pkg::KIND_YCC;
      end
      yrc_pkg::FMT_UYVY: begin
        in_kind = yrc_pkg::KIND_YCC;
        in_y0   = b1;
        in_y1   = b3;
        in_cb   = b0;
        in_cr   = b2;
      end
      yrc_pkg::FMT_PLANAR: begin
        in_kind = yrc_pkg::KIND_YCC;
        in_y0   = b0;
        in_y1   = b1;
        in_cb   = b2;
        in_cr   = b3;
      end
      yrc_pkg::FMT_RGB565: begin
        in_kind   = yrc_pkg::KIND_DIRECT;
        in_direct = '{b: {b0[4:0], 3'b000},
                      g: {b1[2:0], b0[7:5], 2'b00},
                      r: {b1[7:3], 3'b000}};
      end
      yrc_pkg::FMT_BGRX32, yrc_pkg::FMT_BGR24: begin
        in_kind = yrc_pkg::KIND_DIRECT;
      end
      default: begin
        in_kind = yrc_pkg::KIND_NONE;
      end
    endcase
  end

  // Raise busy after a two-pixel word is taken so the output port keeps up.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ctl_a <= '0;
      ctl_b <= '0;
      ctl_c <= '0;
    end else begin
      busy  <= accept && (in_kind == yrc_pkg::KIND_YCC);
      ctl_a <= '{valid: accept && (in_kind != yrc_pkg::KIND_NONE), kind: in_kind};
      ctl_b <= ctl_a;
      ctl_c <= ctl_b;
    end
  end

  always_ff @(posedge clk) begin
    y0_a     <= in_y0;
    y1_a     <= in_y1;
    cb_a     <= in_cb;
    cr_a     <= in_cr;
    direct_a <= in_direct;
    direct_b <= direct_a;
    direct_c <= direct_b;
  end

  yrc_lane u_lane0 (
    .clk (clk),
    .y   (y0_a),
    .cb  (cb_a),
    .cr  (cr_a),
    .pix (pix0)
  );

  yrc_lane u_lane1 (
    .clk (clk),
    .y   (y1_a),
    .cb  (cb_a),
    .cr  (cr_a),
    .pix (pix1)
  );

  yrc_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl_c),
    .pix0    (pix0),
    .pix1    (pix1),
    .direct  (direct_c),
    .strobe  (strobe),
    .last    (last),
    .pix_out (pix_out)
  );

  assign blue  = pix_out.b;
  assign green = pix_out.g;
  assign red   = pix_out.r;

  `ASSERT_CLK(a_busy_after_pair, clk, rst, busy |-> $past(start),
              "busy raised without a word taken in the previous cycle")
  `ASSERT_CLK(a_fixed_latency, clk, rst,
              accept && (in_kind != yrc_pkg::KIND_NONE) |-> ##4 strobe,
              "taken word produced no pixel at the expected cycle")
  `ASSERT_NEVER(a_no_spurious, clk, rst, strobe && !$past(ctl_c.valid) && !$past(busy, 4),
                "pixel strobe without a word behind it")

endmodule

// ===== tb/tb_yuv_rgb_pixel_format_converter.sv =====
module tb_yuv_rgb_pixel_format_converter;
  timeunit 1ns;
  timeprecision 1ps;

  // Format codes that the block decodes to nothing.
  localparam logic [2:0] FMT_SPARE6 = 3'd6;
  localparam logic [2:0] FMT_SPARE7 = 3'd7;
  localparam int DrainCycles = 10;
  localparam int NumPhases = 12;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        format_we = 1'b0;
  logic [2:0]  format_data = 3'd0;
  logic        start = 1'b0;
  logic [31:0] pixel_word = 32'd0;
  logic        busy;
  logic        strobe;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic        last;

  logic [31:0] word_queue [$];
  pixel_t      expected_pixels [$];
  logic [2:0]  cur_fmt = yrc_pkg::FMT_YUY2;
  int          send_idle_pct = 0;
  int          errors = 0;
  int          pixels_checked = 0;
  int          words_by_fmt [8];

  yuv_rgb_pixel_format_converter dut (
    .clk(clk),
    .rst(rst),
    .format_we(format_we),
    .format_data(format_data),
    .start(start),
    .pixel_word(pixel_word),
    .busy(busy),
    .strobe(strobe),
    .blue(blue),
    .green(green),
    .red(red),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Floor shift by 8, then saturate to 0..255.
  function automatic logic [7:0] clip8(input int acc);
    int v;
    if (acc < 0) begin
      return 8'd0;
    end
    v = acc >>> 8;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic pixel_t bt601_pixel(input int y, input int cb, input int cr,
                                         input logic lst);
    int c;
    int d;
    int e;
    pixel_t px;
    c = y - 16;
    d = cb - 128;
    e = cr - 128;
    px.r = clip8(298 * c + 409 * e + 128);
    px.g = clip8(298 * c - 100 * d - 208 * e + 128);
    px.b = clip8(298 * c + 516 * d + 128);
    px.last = lst;
    return px;
  endfunction

  task automatic predict_pixels(input logic [31:0] w);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    pixel_t px;
    {b3, b2, b1, b0} = w;
    words_by_fmt[cur_fmt]++;
    case (cur_fmt)
      yrc_pkg::FMT_YUY2: begin
        expected_pixels.push_back(bt601_pixel(b0, b1, b3, 1'b0));
        expected_pixels.push_back(bt601_pixel(b2, b1, b3, 1'b1));
      end
      yrc_pkg::FMT_UYVY: begin
        expected_pixels.push_back(bt601_pixel(b1, b0, b2, 1'b0));
        expected_pixels.push_back(bt601_pixel(b3, b0, b2, 1'b1));
      end
      yrc_pkg::FMT_PLANAR: begin
        expected_pixels.push_back(bt601_pixel(b0, b2, b3, 1'b0));
        expected_pixels.push_back(bt601_pixel(b1, b2, b3, 1'b1));
      end
      yrc_pkg::FMT_RGB565: begin
        px.b = {w[4:0], 3'b000};
        px.g = {w[10:5], 2'b00};
        px.r = {w[15:11], 3'b000};
        px.last = 1'b1;
        expected_pixels.push_back(px);
      end
      yrc_pkg::FMT_BGRX32, yrc_pkg::FMT_BGR24: begin
        expected_pixels.push_back({b0, b1, b2, 1'b1});
      end
      default: begin
        // unused code: drop the word
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Hold until the sender is empty and every pixel has arrived, then let the
  // pipeline settle for words that make no pixel.
  task automatic wait_drained();
    do @(negedge clk);
    while (word_queue.size() != 0 || start || expected_pixels.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_pixels(pixel_word);
      end
      if (!start || !busy) begin
        if (word_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          start <= 1'b1;
          pixel_word <= word_queue.pop_front();
        end else begin
          start <= 1'b0;
          pixel_word <= $urandom;
        end
      end
    end
  end

  // Monitor: each strobe carries one pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && strobe) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, blue", blue, 0);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (blue !== want.b) report_mismatch("blue", blue, want.b);
        if (green !== want.g) report_mismatch("green", green, want.g);
        if (red !== want.r) report_mismatch("red", red, want.r);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[yuv_rgb_pixel_format_converter] ERROR");
    $finish;
  end

  initial begin
    logic [2:0]  phase_fmt [NumPhases];
    int          idle_tab [4];
    logic        fmt_seen [8];
    logic [31:0] w;
    int          n;
    int          split;
    phase_fmt = '{yrc_pkg::FMT_YUY2, yrc_pkg::FMT_UYVY, yrc_pkg::FMT_PLANAR,
                  yrc_pkg::FMT_RGB565, yrc_pkg::FMT_BGRX32, yrc_pkg::FMT_BGR24,
                  FMT_SPARE6, yrc_pkg::FMT_PLANAR, yrc_pkg::FMT_YUY2,
                  FMT_SPARE7, yrc_pkg::FMT_UYVY, yrc_pkg::FMT_RGB565};
    // receiver stalls do not apply, so entries 0 and 2 run the sender without idling
    idle_tab = '{0, 75, 0, 8};
    foreach (fmt_seen[i]) fmt_seen[i] = 1'b0;
    foreach (words_by_fmt[i]) words_by_fmt[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      @(posedge clk);
      format_we <= 1'b1;
      format_data <= phase_fmt[p];
      @(posedge clk);
      format_we <= 1'b0;
      cur_fmt = phase_fmt[p];
      send_idle_pct = idle_tab[p % 4];

      if (!fmt_seen[phase_fmt[p]]) begin
        fmt_seen[phase_fmt[p]] = 1'b1;
        case (phase_fmt[p])
          yrc_pkg::FMT_YUY2, yrc_pkg::FMT_UYVY, yrc_pkg::FMT_PLANAR: begin
            // all zeros, full scale, black (in YUY2), and chroma pinned at both rails
            word_queue.push_back(32'h0000_0000);
            word_queue.push_back(32'hFFFF_FFFF);
            word_queue.push_back(32'h8010_8010);
            word_queue.push_back(32'hFF00_FF00);
            word_queue.push_back(32'h00FF_00FF);
          end
          yrc_pkg::FMT_RGB565: begin
            word_queue.push_back(32'h0000_0000);
            word_queue.push_back(32'h0000_FFFF);
            word_queue.push_back(32'h0000_001F);
            word_queue.push_back(32'h0000_07E0);
            word_queue.push_back(32'h0000_F800);
            word_queue.push_back(32'hFFFF_0000);
          end
          yrc_pkg::FMT_BGRX32: begin
            word_queue.push_back(32'h0000_0000);
            word_queue.push_back(32'hFFFF_FFFF);
            word_queue.push_back(32'hFF00_0000);
          end
          yrc_pkg::FMT_BGR24: begin
            word_queue.push_back(32'h12_34_56_78);
            word_queue.push_back(32'h00FF_FFFF);
          end
          default: begin
            word_queue.push_back(32'hFFFF_FFFF);
          end
        endcase
      end

      n = (phase_fmt[p] > yrc_pkg::FMT_BGR24) ? 10 : 50;
      split = $urandom_range(n - 1, 1);
      for (int i = 0; i < n; i++) begin
        // pause mid-phase until the pipeline is empty
        if (i == split) wait_drained();
        if ($urandom_range(1, 0)) begin
          w = $urandom;
        end else begin
          for (int k = 0; k < 4; k++) begin
            case ($urandom_range(5, 0))
              0: w[8*k +: 8] = 8'h00;
              1: w[8*k +: 8] = 8'h10;
              2: w[8*k +: 8] = 8'h80;
              3: w[8*k +: 8] = 8'hEB;
              4: w[8*k +: 8] = 8'hFF;
              default: w[8*k +: 8] = 8'($urandom_range(255, 0));
            endcase
          end
        end
        word_queue.push_back(w);
      end
    end

    wait_drained();
    $display("Ran %0d format phases with sender gaps of 0, 8 and 75 percent; ", NumPhases,
             "%0d pixels checked.", pixels_checked);
    $display("Words: yuy2 %0d, uyvy %0d, planar %0d, ", words_by_fmt[yrc_pkg::FMT_YUY2],
             words_by_fmt[yrc_pkg::FMT_UYVY], words_by_fmt[yrc_pkg::FMT_PLANAR],
             "rgb565 %0d, bgrx32 %0d, bgr24 %0d, ", words_by_fmt[yrc_pkg::FMT_RGB565],
             words_by_fmt[yrc_pkg::FMT_BGRX32], words_by_fmt[yrc_pkg::FMT_BGR24],
             "unused %0d", words_by_fmt[FMT_SPARE6] + words_by_fmt[FMT_SPARE7]);
    if (errors == 0) begin
      $display("[yuv_rgb_pixel_format_converter] OK");
    end else begin
      $display("[yuv_rgb_pixel_format_converter] ERROR");
    end
    $finish;
  end

endmodule
